### src/n2kfp_pkg.sv
// Shared types and constants for the NMEA 2000 fast-packet CAN framer.
`timescale 1ns / 1ps

package n2kfp_pkg;

   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 104;
   localparam int RSP_ITEM_W  = 100;

   localparam int GROUP_BITS = 18;
   localparam int FIRST_DATA = 6;
   localparam int NEXT_DATA  = 7;
   localparam int INDEX_W    = 5;

   localparam logic [3:0] FULL_FRAME_BYTES = 4'd8;
   localparam logic       EXT_FRAME_FLAG   = 1'b1;

   // One input transfer; last field in the low bits.
   typedef struct packed {
      logic [7:0]  payload_length;
      logic [7:0]  source;
      logic [7:0]  destination;
      logic [23:0] group_number;
      logic [2:0]  priority_req;
      logic [7:0]  payload_byte;
   } req_item_type;

   // One output frame; last field in the low bits.
   typedef struct packed {
      logic [63:0] frame_bytes;
      logic [3:0]  frame_length;
      logic [31:0] can_id;
   } rsp_item_type;

endpackage

### src/n2k_fast_packet_can_framer_unit.sv
// Top level of the NMEA 2000 fast-packet CAN framer.
`timescale 1ns / 1ps

// Usage:
//   req_* : one message payload byte per transfer, with the message header
//           (priority, group number, destination, source, length) repeated
//           on every transfer of the message.
//   rsp_* : one extended CAN frame per transfer; rsp_tlast marks the frame
//           that completes the message.
//   Messages of up to eight bytes leave as one frame. Longer messages are
//   split into fast-packet frames: frame 0 carries index, length and six
//   bytes, later frames the index and seven bytes. A group number of 2^18
//   or more, a zero length or an oversized length drops the message without output.
// Timing: a transfer is taken into an input register, then one pass of
//   logic builds the frame into the output register. One byte is taken per
//   cycle while the output register is free or being drained.
// Reset clears the message state and both valid flags. When the receiver
//   stalls, the output holds and the held input stage waits, so req_tready
//   drops after at most one further transfer.
module n2k_fast_packet_can_framer_unit #(
   parameter int MAX_FRAME_INDEX = 31
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [7:0] payload_byte, [10:8] priority_req, [34:11] group_number,
   // [42:35] destination, [50:43] source, [58:51] payload_length, rest zero
   input  logic [n2kfp_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] can_id, [35:32] frame_length, [99:36] frame_bytes, rest zero
   output logic [n2kfp_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                              rsp_tlast
);
   import n2kfp_pkg::*;

   localparam logic [8:0] MAX_MSG_BYTES =
      9'(FIRST_DATA + NEXT_DATA * (MAX_FRAME_INDEX - 1));
   localparam logic [INDEX_W-1:0] INDEX_LIMIT = INDEX_W'(MAX_FRAME_INDEX);

   // input stage
   logic         s1_valid_ff, s1_valid_in;
   req_item_type s1_item_ff;

   // message state
   logic [7:0]         bytes_taken_ff, bytes_taken_in;
   logic [INDEX_W-1:0] frame_counter_ff, frame_counter_in;
   logic [63:0]        assembly_word_ff, assembly_word_in;
   logic [3:0]         fill_count_ff, fill_count_in;

   // output stage
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;
   logic         rsp_last_ff, rsp_last_in;

   logic        out_free, s1_go;
   logic        msg_end, drop, multi, emit;
   logic [3:0]  start_slot, fill_next, dlc;
   logic [63:0] base_word, merged_word, masked_word;
   logic [17:0] grp;
   logic [7:0]  id_mid;

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign s1_go       = s1_valid_ff && out_free;
   assign req_tready  = !s1_valid_ff || out_free;
   assign s1_valid_in = (req_tvalid && req_tready) ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);

   always_comb begin
      msg_end = ({1'b0, bytes_taken_ff} + 9'd1) >= {1'b0, s1_item_ff.payload_length};
      drop    = (s1_item_ff.group_number[23:GROUP_BITS] != '0)
             || ({1'b0, s1_item_ff.payload_length} > MAX_MSG_BYTES)
             || (s1_item_ff.payload_length == 8'd0);
      multi   = s1_item_ff.payload_length > 8'd8;

      if (!multi) begin
         // single frame: slots past 7 overwrite slot 7
         base_word  = (fill_count_ff == 4'd0) ? 64'd0 : assembly_word_ff;
         start_slot = (fill_count_ff > 4'd7) ? 4'd7 : fill_count_ff;
      end else if (fill_count_ff == 4'd0) begin
         base_word = {59'd0, frame_counter_ff};
         if (frame_counter_ff == '0) begin
            base_word[15:8] = s1_item_ff.payload_length;
            start_slot      = 4'd2;
         end else begin
            start_slot = 4'd1;
         end
      end else begin
         base_word  = assembly_word_ff;
         start_slot = fill_count_ff;
      end

      for (int k = 0; k < 8; k++) begin
         merged_word[k*8 +: 8] = (start_slot[2:0] == 3'(k)) ?
                                 s1_item_ff.payload_byte : base_word[k*8 +: 8];
      end

      fill_next = start_slot + 4'd1;
      if (multi) begin
         emit = (fill_next >= FULL_FRAME_BYTES) || msg_end;
         dlc  = (fill_next > FULL_FRAME_BYTES) ? FULL_FRAME_BYTES : fill_next;
      end else begin
         emit = msg_end;
         dlc  = fill_next;
      end

      for (int k = 0; k < 8; k++) begin
         masked_word[k*8 +: 8] = (4'(k) < dlc) ? merged_word[k*8 +: 8] : 8'd0;
      end

      grp    = s1_item_ff.group_number[GROUP_BITS-1:0];
      id_mid = (grp[7:0] == 8'd0) ? s1_item_ff.destination : grp[7:0];

      rsp_item_in.can_id       = {EXT_FRAME_FLAG, 2'b00, s1_item_ff.priority_req,
                                  grp[17:8], id_mid, s1_item_ff.source};
      rsp_item_in.frame_length = dlc;
      rsp_item_in.frame_bytes  = masked_word;
      rsp_last_in              = msg_end;
   end

   always_comb begin
      bytes_taken_in   = bytes_taken_ff;
      frame_counter_in = frame_counter_ff;
      assembly_word_in = assembly_word_ff;
      fill_count_in    = fill_count_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      if (s1_go) begin
         rsp_valid_in = emit && !drop;
         if (!drop) begin
            if (emit) begin
               assembly_word_in = 64'd0;
               fill_count_in    = 4'd0;
               if (frame_counter_ff < INDEX_LIMIT) begin
                  frame_counter_in = frame_counter_ff + INDEX_W'(1);
               end
            end else begin
               assembly_word_in = merged_word;
               fill_count_in    = fill_next;
            end
         end
         if (msg_end) begin
            bytes_taken_in   = 8'd0;
            frame_counter_in = '0;
            assembly_word_in = 64'd0;
            fill_count_in    = 4'd0;
         end else begin
            bytes_taken_in = bytes_taken_ff + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         bytes_taken_ff   <= 8'd0;
         frame_counter_ff <= '0;
         assembly_word_ff <= 64'd0;
         fill_count_ff    <= 4'd0;
      end else begin
         s1_valid_ff      <= s1_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
         bytes_taken_ff   <= bytes_taken_in;
         frame_counter_ff <= frame_counter_in;
         assembly_word_ff <= assembly_word_in;
         fill_count_ff    <= fill_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_item_ff <= req_item_type'(req_tdata[$bits(req_item_type)-1:0]);
      end
      if (s1_go) begin
         rsp_item_ff <= rsp_item_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - RSP_ITEM_W)'(0), rsp_item_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

### src/n2kfp_checker.sv
// Port-level checker for the fast-packet CAN framer, with its bind.
`timescale 1ns / 1ps

module n2kfp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [n2kfp_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                              rsp_tlast
);
   import n2kfp_pkg::*;

   // a stalled frame holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp frame changed while stalled");

   // every frame carries the extended-frame flag
   a_ext_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31])
      else $error("can_id without extended flag");

   // length code stays in 1..8
   a_dlc_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[35:32] != 4'd0) && (rsp_tdata[35:32] <= FULL_FRAME_BYTES))
      else $error("frame_length out of range");

   // only the closing frame of a message may be short
   a_full_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[35:32] == FULL_FRAME_BYTES)
      else $error("short frame before end of message");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

endmodule

bind n2k_fast_packet_can_framer_unit n2kfp_checker u_n2kfp_checker (.*);
